// ===== src/rcht_pkg.sv =====
// ----------------------------------------------------------------------------
// rcht_pkg: shared types and codes of the reference-counted handle table
// Holds field widths, command and status codes and the entry write request.
// ----------------------------------------------------------------------------
package rcht_pkg;

  localparam int CMD_W    = 2;
  localparam int HANDLE_W = 7;
  localparam int TAG_W    = 32;
  localparam int CNT_W    = 8;
  localparam int STATUS_W = 3;

  // Largest count the count field can hold
  localparam int CNT_CEIL = (1 << CNT_W) - 1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_LIVE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW  = 3'd6;

  // Write request from the update logic to the entry store
  typedef struct packed {
    logic                cnt_we;
    logic                tag_we;
    logic [HANDLE_W-1:0] addr;
    logic [CNT_W-1:0]    cnt;
    logic [TAG_W-1:0]    tag;
  } rcht_wr_t;

endpackage

// ===== src/rcht_prio_enc.sv =====
// ----------------------------------------------------------------------------
// rcht_prio_enc: lowest-set-bit priority encoder
// Finds the lowest request bit that is set and returns its index.
// ----------------------------------------------------------------------------
module rcht_prio_enc #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]         req,
  output logic                     found,
  output logic [$clog2(WIDTH)-1:0] idx
);

  localparam int IDXW = $clog2(WIDTH);

  // Scan from the top so the lowest set bit wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (req[i]) begin
        found = 1'b1;
        idx   = IDXW'(i);
      end
    end
  end

endmodule

// ===== src/rcht_store.sv =====
// ----------------------------------------------------------------------------
// rcht_store: reference count and owner tag memories
// One registered read port and one write port, with forwarding of a write
// that lands on the address read in the same cycle.
// ----------------------------------------------------------------------------
module rcht_store #(
  parameter int ENTRIES = 64
) (
  input  logic                                clk,
  input  logic [$clog2(ENTRIES)-1:0]          rd_addr,
  input  rcht_pkg::rcht_wr_t                  wr,
  output logic [rcht_pkg::CNT_W-1:0]          rd_cnt,
  output logic [rcht_pkg::TAG_W-1:0]          rd_tag
);

  localparam int IDXW = $clog2(ENTRIES);

  logic [rcht_pkg::CNT_W-1:0] cnt_mem [ENTRIES];
  logic [rcht_pkg::TAG_W-1:0] tag_mem [ENTRIES];

  logic [rcht_pkg::CNT_W-1:0] cnt_rd_r;
  logic [rcht_pkg::TAG_W-1:0] tag_rd_r;
  logic [rcht_pkg::CNT_W-1:0] cnt_fwd_r;
  logic [rcht_pkg::TAG_W-1:0] tag_fwd_r;
  logic                       cnt_hit_r;
  logic                       tag_hit_r;
  logic [IDXW-1:0]            wr_idx;

  assign wr_idx = wr.addr[IDXW-1:0];

  // Read the old contents and write the new ones
  always_ff @(posedge clk) begin
    cnt_rd_r <= cnt_mem[rd_addr];
    tag_rd_r <= tag_mem[rd_addr];
    if (wr.cnt_we) begin
      cnt_mem[wr_idx] <= wr.cnt;
    end
    if (wr.tag_we) begin
      tag_mem[wr_idx] <= wr.tag;
    end
  end

  // Capture a write that collides with this cycle's read
  always_ff @(posedge clk) begin
    cnt_hit_r <= wr.cnt_we && (wr_idx == rd_addr);
    tag_hit_r <= wr.tag_we && (wr_idx == rd_addr);
    cnt_fwd_r <= wr.cnt;
    tag_fwd_r <= wr.tag;
  end

  assign rd_cnt = cnt_hit_r ? cnt_fwd_r : cnt_rd_r;
  assign rd_tag = tag_hit_r ? tag_fwd_r : tag_rd_r;

endmodule

// ===== src/refcounted_handle_table_top.sv =====
// ----------------------------------------------------------------------------
// refcounted_handle_table_top: reference-counted handle table
// A command is taken whenever start is high and busy is low; busy never rises,
// so one command can be issued in every cycle. Each command gives exactly one
// result, shown on the out_ ports for one cycle with out_valid high. The count
// and tag memory read happens at the transfer edge, and the update lands in
// the result register at the next edge. The receiver cannot stall the result,
// so it must capture it in the cycle out_valid is high. A command sees the
// effect of every command issued before it.
// ----------------------------------------------------------------------------
module refcounted_handle_table_top #(
  parameter int ENTRIES  = 64,
  parameter int MAX_REFS = 255
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [rcht_pkg::CMD_W-1:0]       in_command,
  input  logic [rcht_pkg::HANDLE_W-1:0]    in_handle,
  input  logic [rcht_pkg::TAG_W-1:0]       in_owner_tag,
  output logic                             out_valid,
  output logic [rcht_pkg::STATUS_W-1:0]    out_status,
  output logic [rcht_pkg::HANDLE_W-1:0]    out_result_handle,
  output logic [rcht_pkg::TAG_W-1:0]       out_result_tag,
  output logic [rcht_pkg::CNT_W-1:0]       out_count_after
);

  localparam int IDXW = $clog2(ENTRIES);
  localparam logic [rcht_pkg::HANDLE_W:0] ENTRIES_C = (rcht_pkg::HANDLE_W + 1)'(ENTRIES);
  localparam logic [rcht_pkg::CNT_W-1:0] REF_CAP =
    rcht_pkg::CNT_W'((MAX_REFS < rcht_pkg::CNT_CEIL) ? MAX_REFS : rcht_pkg::CNT_CEIL);

  // Input register
  logic                          s1_valid_r;
  logic [rcht_pkg::CMD_W-1:0]    s1_cmd_r;
  logic [rcht_pkg::HANDLE_W-1:0] s1_handle_r;
  logic [rcht_pkg::TAG_W-1:0]    s1_tag_r;

  // Allocated bits, also the valid bits of the count memory
  logic [ENTRIES-1:0] alloc_map_r;
  logic [ENTRIES-1:0] alloc_map_nxt;

  // Result register
  logic                            out_valid_r;
  logic [rcht_pkg::STATUS_W-1:0]   status_r;
  logic [rcht_pkg::HANDLE_W-1:0]   handle_r;
  logic [rcht_pkg::TAG_W-1:0]      tag_r;
  logic [rcht_pkg::CNT_W-1:0]      cnt_r;
  logic [rcht_pkg::STATUS_W-1:0]   status_nxt;
  logic [rcht_pkg::HANDLE_W-1:0]   handle_nxt;
  logic [rcht_pkg::TAG_W-1:0]      tag_nxt;
  logic [rcht_pkg::CNT_W-1:0]      cnt_nxt;

  logic                          accept;
  logic [IDXW-1:0]               s1_idx;
  logic                          in_range;
  logic [rcht_pkg::CNT_W-1:0]    mem_cnt;
  logic [rcht_pkg::TAG_W-1:0]    mem_tag;
  logic [rcht_pkg::CNT_W-1:0]    cur_cnt;
  logic [rcht_pkg::CNT_W-1:0]    cnt_inc;
  logic [rcht_pkg::CNT_W-1:0]    cnt_dec;
  logic                          free_found;
  logic [IDXW-1:0]               free_idx;
  logic                          alloc_ok;
  logic                          free_ok;
  rcht_pkg::rcht_wr_t            wr;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Capture the command on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r    <= in_command;
    s1_handle_r <= in_handle;
    s1_tag_r    <= in_owner_tag;
  end

  rcht_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk     (clk),
    .rd_addr (in_handle[IDXW-1:0]),
    .wr      (wr),
    .rd_cnt  (mem_cnt),
    .rd_tag  (mem_tag)
  );

  rcht_prio_enc #(
    .WIDTH (ENTRIES)
  ) u_prio_enc (
    .req   (~alloc_map_r),
    .found (free_found),
    .idx   (free_idx)
  );

  assign s1_idx   = s1_handle_r[IDXW-1:0];
  assign in_range = {1'b0, s1_handle_r} < ENTRIES_C;
  assign cur_cnt  = alloc_map_r[s1_idx] ? mem_cnt : '0;
  assign cnt_inc  = cur_cnt + rcht_pkg::CNT_W'(1);
  assign cnt_dec  = cur_cnt - rcht_pkg::CNT_W'(1);

  // Decide the result and the entry update
  always_comb begin
    alloc_map_nxt = alloc_map_r;
    status_nxt    = rcht_pkg::ST_OK;
    handle_nxt    = s1_handle_r;
    tag_nxt       = '0;
    cnt_nxt       = '0;
    wr.cnt_we     = 1'b0;
    wr.tag_we     = 1'b0;
    wr.addr       = s1_handle_r;
    wr.cnt        = '0;
    wr.tag        = s1_tag_r;
    alloc_ok      = 1'b0;
    free_ok       = 1'b0;
    if (s1_cmd_r == rcht_pkg::CMD_ALLOC) begin
      handle_nxt = '0;
      if (free_found) begin
        alloc_ok   = s1_valid_r;
        handle_nxt = rcht_pkg::HANDLE_W'(free_idx);
        cnt_nxt    = rcht_pkg::CNT_W'(1);
        wr.addr    = rcht_pkg::HANDLE_W'(free_idx);
        wr.cnt     = rcht_pkg::CNT_W'(1);
        wr.cnt_we  = s1_valid_r;
        wr.tag_we  = s1_valid_r;
        if (s1_valid_r) begin
          alloc_map_nxt[free_idx] = 1'b1;
        end
      end else begin
        status_nxt = rcht_pkg::ST_FULL;
      end
    end else if (!in_range) begin
      status_nxt = rcht_pkg::ST_BAD_HANDLE;
    end else begin
      case (s1_cmd_r)
        rcht_pkg::CMD_GET: begin
          if (cur_cnt == '0) begin
            status_nxt = rcht_pkg::ST_NOT_LIVE;
          end else if (cur_cnt >= REF_CAP) begin
            status_nxt = rcht_pkg::ST_SATURATED;
            cnt_nxt    = cur_cnt;
          end else begin
            cnt_nxt   = cnt_inc;
            tag_nxt   = mem_tag;
            wr.cnt    = cnt_inc;
            wr.cnt_we = s1_valid_r;
          end
        end
        rcht_pkg::CMD_PUT: begin
          if (cur_cnt == '0) begin
            status_nxt = rcht_pkg::ST_UNDERFLOW;
          end else begin
            cnt_nxt    = cnt_dec;
            wr.cnt     = cnt_dec;
            wr.cnt_we  = s1_valid_r;
            status_nxt = (cnt_dec == '0) ? rcht_pkg::ST_UNDERFLOW : rcht_pkg::ST_OK;
          end
        end
        default: begin
          if (cur_cnt != rcht_pkg::CNT_W'(1)) begin
            status_nxt = rcht_pkg::ST_BUSY;
            cnt_nxt    = cur_cnt;
          end else begin
            free_ok   = s1_valid_r;
            tag_nxt   = mem_tag;
            wr.cnt_we = s1_valid_r;
            if (s1_valid_r) begin
              alloc_map_nxt[s1_idx] = 1'b0;
            end
          end
        end
      endcase
    end
  end

  // Advance the allocated bits and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_map_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      alloc_map_r <= alloc_map_nxt;
      out_valid_r <= s1_valid_r;
    end
  end

  // Hold the result for its single cycle of transfer
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    handle_r <= handle_nxt;
    tag_r    <= tag_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_result_handle = handle_r;
  assign out_result_tag    = tag_r;
  assign out_count_after   = cnt_r;

  // Every accepted command yields a result with out_valid high
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("accepted command produced no result");

  // A granted allocation reports a single reference
  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_ok |=> (out_status == rcht_pkg::ST_OK) && (out_count_after == rcht_pkg::CNT_W'(1)))
    else $error("allocation result mismatch");

  // A granted allocation marks exactly one more entry
  a_alloc_map: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_ok |=> $countones(alloc_map_r) == $countones($past(alloc_map_r)) + 1)
    else $error("allocation did not set one bit");

  // A successful free releases exactly one entry
  a_free_map: assert property (@(posedge clk) disable iff (!rst_n)
    free_ok |=> $countones(alloc_map_r) == $countones($past(alloc_map_r)) - 1)
    else $error("free did not clear one bit");

  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= rcht_pkg::ST_UNDERFLOW)
    else $error("undefined status code");

endmodule

// ===== tb/refcounted_handle_table_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_handle_table_top_tb: self-checking bench for the handle table
// Opens with a short table of commands covering the error paths, the
// allocate/free round trip and a put down to zero, then runs random commands
// steered towards live handles, with a table fill and a count pump to the
// ceiling. A software copy of the table predicts each result not written by
// hand in the table. Results are checked field by field in issue order.
// ----------------------------------------------------------------------------
module refcounted_handle_table_top_tb;

  localparam int NUM_HANDLES = 64;
  localparam int REF_LIMIT   = 255;
  localparam int REF_CEIL    =
    (REF_LIMIT < rcht_pkg::CNT_CEIL) ? REF_LIMIT : rcht_pkg::CNT_CEIL;
  localparam int CYCLE_LIMIT = 100000;
  localparam int LEAK_BUDGET = 10;
  localparam int TAIL_CYCLES = 4;
  localparam int PLAN_ROWS   = 22;

  typedef struct packed {
    logic [rcht_pkg::STATUS_W-1:0] status;
    logic [rcht_pkg::HANDLE_W-1:0] handle;
    logic [rcht_pkg::TAG_W-1:0]    tag;
    logic [rcht_pkg::CNT_W-1:0]    count;
  } table_result_t;

  typedef struct packed {
    logic [rcht_pkg::CMD_W-1:0]    cmd;
    logic [rcht_pkg::HANDLE_W-1:0] hnd;
    logic [rcht_pkg::TAG_W-1:0]    tag;
    logic                          typed;
    table_result_t                 want;
  } plan_row_t;

  localparam table_result_t NO_WANT = '0;

  // Directed commands; rows with typed set carry a hand-written result
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // empty table: get, put and free on a dead handle
    '{rcht_pkg::CMD_GET,   7'd0,   32'h0,        1'b1,
      '{rcht_pkg::ST_NOT_LIVE,   7'd0,   32'h0,        8'd0}},
    '{rcht_pkg::CMD_PUT,   7'd0,   32'h0,        1'b1,
      '{rcht_pkg::ST_UNDERFLOW,  7'd0,   32'h0,        8'd0}},
    '{rcht_pkg::CMD_FREE,  7'd0,   32'h0,        1'b1,
      '{rcht_pkg::ST_BUSY,       7'd0,   32'h0,        8'd0}},
    // handles out of range
    '{rcht_pkg::CMD_GET,   7'd127, 32'h0,        1'b1,
      '{rcht_pkg::ST_BAD_HANDLE, 7'd127, 32'h0,        8'd0}},
    '{rcht_pkg::CMD_FREE,  7'd64,  32'h0,        1'b1,
      '{rcht_pkg::ST_BAD_HANDLE, 7'd64,  32'h0,        8'd0}},
    '{rcht_pkg::CMD_PUT,   7'd100, 32'h0,        1'b1,
      '{rcht_pkg::ST_BAD_HANDLE, 7'd100, 32'h0,        8'd0}},
    // allocate ignores the handle field
    '{rcht_pkg::CMD_ALLOC, 7'd127, 32'hFFFFFFFF, 1'b1,
      '{rcht_pkg::ST_OK,         7'd0,   32'h0,        8'd1}},
    '{rcht_pkg::CMD_ALLOC, 7'd0,   32'h0,        1'b1,
      '{rcht_pkg::ST_OK,         7'd1,   32'h0,        8'd1}},
    '{rcht_pkg::CMD_GET,   7'd0,   32'h0,        1'b1,
      '{rcht_pkg::ST_OK,         7'd0,   32'hFFFFFFFF, 8'd2}},
    // free while more than one reference is held
    '{rcht_pkg::CMD_FREE,  7'd0,   32'h0,        1'b1,
      '{rcht_pkg::ST_BUSY,       7'd0,   32'h0,        8'd2}},
    '{rcht_pkg::CMD_PUT,   7'd0,   32'h0,        1'b1,
      '{rcht_pkg::ST_OK,         7'd0,   32'h0,        8'd1}},
    '{rcht_pkg::CMD_FREE,  7'd0,   32'h0,        1'b1,
      '{rcht_pkg::ST_OK,         7'd0,   32'hFFFFFFFF, 8'd0}},
    // lowest free handle is reused
    '{rcht_pkg::CMD_ALLOC, 7'd55,  32'h5A5AA5A5, 1'b1,
      '{rcht_pkg::ST_OK,         7'd0,   32'h0,        8'd1}},
    '{rcht_pkg::CMD_GET,   7'd1,   32'h0,        1'b0, NO_WANT},
    '{rcht_pkg::CMD_PUT,   7'd1,   32'h0,        1'b0, NO_WANT},
    // put down to zero leaves the entry allocated but dead
    '{rcht_pkg::CMD_PUT,   7'd1,   32'h0,        1'b1,
      '{rcht_pkg::ST_UNDERFLOW,  7'd1,   32'h0,        8'd0}},
    '{rcht_pkg::CMD_GET,   7'd1,   32'h0,        1'b1,
      '{rcht_pkg::ST_NOT_LIVE,   7'd1,   32'h0,        8'd0}},
    '{rcht_pkg::CMD_FREE,  7'd1,   32'h0,        1'b1,
      '{rcht_pkg::ST_BUSY,       7'd1,   32'h0,        8'd0}},
    '{rcht_pkg::CMD_ALLOC, 7'd0,   32'h12345678, 1'b0, NO_WANT},
    '{rcht_pkg::CMD_GET,   7'd63,  32'h0,        1'b1,
      '{rcht_pkg::ST_NOT_LIVE,   7'd63,  32'h0,        8'd0}},
    '{rcht_pkg::CMD_FREE,  7'd63,  32'h0,        1'b0, NO_WANT},
    '{rcht_pkg::CMD_GET,   7'd2,   32'h0,        1'b0, NO_WANT}
  };

  localparam int PHASE_IDLE  [3] = '{29, 64, 0};
  localparam int PHASE_ITEMS [3] = '{150, 150, 380};

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [rcht_pkg::CMD_W-1:0]    in_command;
  logic [rcht_pkg::HANDLE_W-1:0] in_handle;
  logic [rcht_pkg::TAG_W-1:0]    in_owner_tag;
  logic                          out_valid;
  logic [rcht_pkg::STATUS_W-1:0] out_status;
  logic [rcht_pkg::HANDLE_W-1:0] out_result_handle;
  logic [rcht_pkg::TAG_W-1:0]    out_result_tag;
  logic [rcht_pkg::CNT_W-1:0]    out_count_after;

  // Shadow copy of the table
  logic                       tbl_live  [NUM_HANDLES];
  logic [rcht_pkg::CNT_W-1:0] tbl_count [NUM_HANDLES];
  logic [rcht_pkg::TAG_W-1:0] tbl_tag   [NUM_HANDLES];

  table_result_t pending_results [$];
  int            mismatches;
  int            cycle_count;
  int            items_sent;
  int            idle_pct;
  int            leaks;

  refcounted_handle_table_top #(
    .ENTRIES  (NUM_HANDLES),
    .MAX_REFS (REF_LIMIT)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_handle         (in_handle),
    .in_owner_tag      (in_owner_tag),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_result_handle (out_result_handle),
    .out_result_tag    (out_result_tag),
    .out_count_after   (out_count_after)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one command to the shadow table and return the result it gives
  function automatic table_result_t apply_to_table(
    input logic [rcht_pkg::CMD_W-1:0]    cmd,
    input logic [rcht_pkg::HANDLE_W-1:0] hnd,
    input logic [rcht_pkg::TAG_W-1:0]    tag);
    table_result_t              res;
    logic [rcht_pkg::CNT_W-1:0] cnt;
    int                         idx;
    res = '0;
    res.handle = hnd;
    if (cmd == rcht_pkg::CMD_ALLOC) begin
      res.status = rcht_pkg::ST_FULL;
      res.handle = '0;
      for (idx = 0; idx < NUM_HANDLES; idx++) begin
        if (!tbl_live[idx] && res.status == rcht_pkg::ST_FULL) begin
          tbl_live[idx]  = 1'b1;
          tbl_tag[idx]   = tag;
          tbl_count[idx] = 8'd1;
          res.status = rcht_pkg::ST_OK;
          res.handle = rcht_pkg::HANDLE_W'(idx);
          res.count  = 8'd1;
        end
      end
      return res;
    end
    if (hnd >= NUM_HANDLES) begin
      res.status = rcht_pkg::ST_BAD_HANDLE;
      return res;
    end
    cnt = tbl_count[hnd];
    case (cmd)
      rcht_pkg::CMD_GET: begin
        if (cnt == 0) begin
          res.status = rcht_pkg::ST_NOT_LIVE;
        end else if (cnt >= REF_CEIL) begin
          res.status = rcht_pkg::ST_SATURATED;
          res.count  = cnt;
        end else begin
          tbl_count[hnd] = cnt + 1'b1;
          res.tag   = tbl_tag[hnd];
          res.count = cnt + 1'b1;
        end
      end
      rcht_pkg::CMD_PUT: begin
        if (cnt == 0) begin
          res.status = rcht_pkg::ST_UNDERFLOW;
        end else begin
          tbl_count[hnd] = cnt - 1'b1;
          res.count  = cnt - 1'b1;
          res.status = (cnt == 1) ? rcht_pkg::ST_UNDERFLOW : rcht_pkg::ST_OK;
        end
      end
      default: begin
        if (cnt != 1) begin
          res.status = rcht_pkg::ST_BUSY;
          res.count  = cnt;
        end else begin
          tbl_count[hnd] = '0;
          tbl_live[hnd]  = 1'b0;
          res.tag = tbl_tag[hnd];
        end
      end
    endcase
    return res;
  endfunction

  // Random live handle, or -1 when none holds a reference
  function automatic int pick_live();
    int base;
    int k;
    base = $urandom_range(NUM_HANDLES - 1);
    for (k = 0; k < NUM_HANDLES; k++) begin
      if (tbl_count[(base + k) % NUM_HANDLES] != 0) return (base + k) % NUM_HANDLES;
    end
    return -1;
  endfunction

  function automatic bit table_has_room();
    int idx;
    for (idx = 0; idx < NUM_HANDLES; idx++) begin
      if (!tbl_live[idx]) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Drive one command, idle first at the current rate, hold until the
  // transfer, then record what the table should answer
  task automatic issue(input logic [rcht_pkg::CMD_W-1:0]    cmd,
                       input logic [rcht_pkg::HANDLE_W-1:0] hnd,
                       input logic [rcht_pkg::TAG_W-1:0]    tag,
                       input bit                            typed,
                       input table_result_t                 typed_want);
    int unsigned   gap;
    table_result_t predicted;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_command   <= cmd;
    in_handle    <= hnd;
    in_owner_tag <= tag;
    do @(posedge clk); while (busy);
    predicted = apply_to_table(cmd, hnd, tag);
    pending_results.push_back(typed ? typed_want : predicted);
    items_sent++;
  endtask

  // Hold off until every outstanding result has been seen
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Allocate until the table is full, then once more to hit the full case
  task automatic fill_table();
    while (table_has_room()) begin
      issue(rcht_pkg::CMD_ALLOC, rcht_pkg::HANDLE_W'($urandom), $urandom, 1'b0, NO_WANT);
    end
    issue(rcht_pkg::CMD_ALLOC, rcht_pkg::HANDLE_W'($urandom), $urandom, 1'b0, NO_WANT);
  endtask

  // Take references on one handle up to the ceiling, then bounce off it
  task automatic pump_to_ceiling();
    int h;
    h = pick_live();
    if (h >= 0) begin
      while (tbl_count[h] < REF_CEIL) begin
        issue(rcht_pkg::CMD_GET, rcht_pkg::HANDLE_W'(h), $urandom, 1'b0, NO_WANT);
      end
      repeat (2) issue(rcht_pkg::CMD_GET, rcht_pkg::HANDLE_W'(h), $urandom, 1'b0, NO_WANT);
    end
  endtask

  // One random command: mostly well-formed traffic on live handles
  task automatic random_command();
    int                         pick;
    int                         roll;
    int                         h;
    logic [rcht_pkg::CMD_W-1:0] cmd;
    pick = $urandom_range(99);
    h = pick_live();
    if (pick < 15) begin
      issue(rcht_pkg::CMD_W'($urandom_range(3)), rcht_pkg::HANDLE_W'($urandom_range(127)),
            $urandom, 1'b0, NO_WANT);
    end else if (pick < 35 || h < 0) begin
      issue(rcht_pkg::CMD_ALLOC, rcht_pkg::HANDLE_W'($urandom), $urandom, 1'b0, NO_WANT);
    end else begin
      roll = $urandom_range(99);
      if (tbl_count[h] == 1) begin
        if (roll < 50) cmd = rcht_pkg::CMD_FREE;
        else if (roll < 96 || leaks >= LEAK_BUDGET) cmd = rcht_pkg::CMD_GET;
        else cmd = rcht_pkg::CMD_PUT;
        if (cmd == rcht_pkg::CMD_PUT) leaks++;
      end else begin
        if (roll < 50) cmd = rcht_pkg::CMD_PUT;
        else if (roll < 85) cmd = rcht_pkg::CMD_GET;
        else cmd = rcht_pkg::CMD_FREE;
      end
      issue(cmd, rcht_pkg::HANDLE_W'(h), $urandom, 1'b0, NO_WANT);
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_status), 32'(0));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_result_handle !== want.handle)
          report_mismatch("result_handle", 32'(out_result_handle), 32'(want.handle));
        if (out_result_tag !== want.tag)
          report_mismatch("result_tag", out_result_tag, want.tag);
        if (out_count_after !== want.count)
          report_mismatch("count_after", 32'(out_count_after), 32'(want.count));
      end
    end
  end

  // Abandon a run that stops making progress
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("refcounted_handle_table_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int  idx;
    int  ph;
    int  phase_start;
    bit  filled;
    bit  pumped;
    start        = 1'b0;
    in_command   = rcht_pkg::CMD_ALLOC;
    in_handle    = '0;
    in_owner_tag = '0;
    rst_n        = 1'b0;
    mismatches   = 0;
    cycle_count  = 0;
    items_sent   = 0;
    idle_pct     = 0;
    leaks        = 0;
    for (idx = 0; idx < NUM_HANDLES; idx++) begin
      tbl_live[idx]  = 1'b0;
      tbl_count[idx] = '0;
      tbl_tag[idx]   = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (idx = 0; idx < PLAN_ROWS; idx++) begin
      issue(PLAN[idx].cmd, PLAN[idx].hnd, PLAN[idx].tag, PLAN[idx].typed, PLAN[idx].want);
    end
    wait_for_results();

    // Random phases at the idle rates in PHASE_IDLE, draining between them
    for (ph = 0; ph < 3; ph++) begin
      idle_pct    = PHASE_IDLE[ph];
      phase_start = items_sent;
      filled      = 1'b0;
      pumped      = 1'b0;
      while (items_sent - phase_start < PHASE_ITEMS[ph]) begin
        if (ph != 0 && !filled && items_sent - phase_start >= 40) begin
          fill_table();
          filled = 1'b1;
        end else if (ph == 2 && !pumped && items_sent - phase_start >= 120) begin
          pump_to_ceiling();
          pumped = 1'b1;
        end else begin
          random_command();
        end
      end
      wait_for_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("refcounted_handle_table_top_tb OK");
    end else begin
      $display("refcounted_handle_table_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rcht_pkg.sv
src/rcht_prio_enc.sv
src/rcht_store.sv
src/refcounted_handle_table_top.sv
tb/refcounted_handle_table_top_tb.sv
